[rtl/assert_macros.svh]
// Assertion macros used by the port checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When the antecedent holds, the consequent must hold in the same cycle.
`define CHK_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define CHK_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/rgss_pkg.sv]
// Shared constants, codes and control types of the rolling grid scroll store.
package rgss_pkg;

    localparam int MAX_RADIUS   = 31;
    localparam int CELL_BITS    = 32;
    localparam int KEY_BITS     = 32;
    localparam int DATA_BITS    = 32;
    localparam int RAD_BITS     = 5;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_BITS     = 32;
    localparam int SIDE_MAX     = 2 * MAX_RADIUS + 1;
    localparam int COORD_BITS   = $clog2(SIDE_MAX + 1);
    localparam int ADDR_BITS    = 2 * COORD_BITS;
    localparam int STORE_DEPTH  = 1 << ADDR_BITS;

    // Request codes.
    localparam logic [1:0] REQ_MOVE  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EMPTY  = 1'd1;

    // Status codes.
    localparam logic [1:0] ST_UNCHANGED = 2'd0;
    localparam logic [1:0] ST_SHIFTED   = 2'd1;
    localparam logic [1:0] ST_REINIT    = 2'd2;
    localparam logic [1:0] ST_OUTSIDE   = 2'd0;
    localparam logic [1:0] ST_INSIDE    = 2'd1;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_move;
        logic is_read;
        logic is_write;
        logic need_init;
        logic moved;
        logic in_window;
        logic init_mode;
        logic sweep_last;
    } rgss_stat_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;
        logic       sweep_start;
        logic       sweep_step;
        logic       ram_read;
        logic       ram_write;
        logic       finish;
        logic [1:0] fin_status;
        logic       use_rd;
    } rgss_cmd_t;

endpackage

[rtl/rolling_grid_scroll_store_top.sv]
// Top level of the rolling grid scroll store: controller, datapath and cell RAM.
// Read: capture, decide, a RAM read wait state, then the registered done strobe.
// Write, out-of-window access and a move that neither changes the origin nor needs
// a reinit finish from decide; other moves sweep one window cell per cycle on the single RAM port.
// One request at a time; start is taken when busy is low, done pulses for one cycle
// and the receiver cannot stall it.
// Asynchronous active-low reset: radius 16, empty word 0, window not initialized.
module rolling_grid_scroll_store_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rgss_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [rgss_pkg::CFG_BITS-1:0]     cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        req_type,
    input  logic signed [rgss_pkg::KEY_BITS-1:0] key_x,
    input  logic signed [rgss_pkg::KEY_BITS-1:0] key_y,
    input  logic [rgss_pkg::DATA_BITS-1:0]    write_data,
    output logic                              done,
    output logic [1:0]                        status,
    output logic [rgss_pkg::DATA_BITS-1:0]    read_data
);
    import rgss_pkg::*;

    rgss_cmd_t  cmd;
    rgss_stat_t stat;

    rgss_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    rgss_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_type   (req_type),
        .key_x      (key_x),
        .key_y      (key_y),
        .write_data (write_data),
        .cmd        (cmd),
        .stat       (stat),
        .done       (done),
        .status     (status),
        .read_data  (read_data)
    );

endmodule

[rtl/rgss_ram.sv]
// Generic single-port RAM with registered read.
module rgss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     we,
    input  logic                     re,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read share the one address.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/rgss_datapath.sv]
// Datapath: configuration, window origin, sweep counters, cell RAM and result registers.
module rgss_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rgss_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [rgss_pkg::CFG_BITS-1:0]     cfg_data,
    input  logic [1:0]                        req_type,
    input  logic [rgss_pkg::KEY_BITS-1:0]     key_x,
    input  logic [rgss_pkg::KEY_BITS-1:0]     key_y,
    input  logic [rgss_pkg::DATA_BITS-1:0]    write_data,
    input  rgss_pkg::rgss_cmd_t               cmd,
    output rgss_pkg::rgss_stat_t              stat,
    output logic                              done,
    output logic [1:0]                        status,
    output logic [rgss_pkg::DATA_BITS-1:0]    read_data
);
    import rgss_pkg::*;

    logic [RAD_BITS-1:0]   cfg_radius_reg;
    logic [CELL_BITS-1:0]  empty_reg;
    logic [1:0]            req_reg;
    logic [KEY_BITS-1:0]   kx_reg;
    logic [KEY_BITS-1:0]   ky_reg;
    logic [CELL_BITS-1:0]  wd_reg;
    logic [RAD_BITS-1:0]   r_reg;
    logic [KEY_BITS-1:0]   origin_x_reg;
    logic [KEY_BITS-1:0]   origin_y_reg;
    logic [RAD_BITS-1:0]   radius_use_reg;
    logic                  ready_reg;
    logic                  init_reg;
    logic [KEY_BITS-1:0]   dx_reg;
    logic [KEY_BITS-1:0]   dy_reg;
    logic [COORD_BITS-1:0] col_reg;
    logic [COORD_BITS-1:0] row_reg;
    logic                  done_reg;
    logic [1:0]            status_reg;
    logic [DATA_BITS-1:0]  read_data_reg;

    logic [RAD_BITS-1:0]   r_eff;
    logic [KEY_BITS-1:0]   nox;
    logic [KEY_BITS-1:0]   noy;
    logic [KEY_BITS-1:0]   dx_now;
    logic [KEY_BITS-1:0]   dy_now;
    logic [COORD_BITS-1:0] side_new;
    logic [COORD_BITS-1:0] side_use;
    logic [KEY_BITS-1:0]   offx_acc;
    logic [KEY_BITS-1:0]   offy_acc;
    logic [KEY_BITS-1:0]   offx_old;
    logic [KEY_BITS-1:0]   offy_old;
    logic [COORD_BITS-1:0] gx_low;
    logic [COORD_BITS-1:0] gy_low;
    logic                  uncovered;
    logic [ADDR_BITS-1:0]  ram_addr;
    logic                  ram_we;
    logic [CELL_BITS-1:0]  ram_wdata;
    logic [CELL_BITS-1:0]  ram_rdata;

    // Effective radius saturates at the largest window the store holds.
    assign r_eff = (cfg_radius_reg > RAD_BITS'(MAX_RADIUS)) ? RAD_BITS'(MAX_RADIUS)
                                                             : cfg_radius_reg;

    // New origin and its distance from the current one, modulo the key width.
    assign nox    = kx_reg - KEY_BITS'(r_reg);
    assign noy    = ky_reg - KEY_BITS'(r_reg);
    assign dx_now = nox - origin_x_reg;
    assign dy_now = noy - origin_y_reg;

    assign side_new = COORD_BITS'({r_reg, 1'b1});
    assign side_use = COORD_BITS'({radius_use_reg, 1'b1});

    // Access offsets relative to the window in use.
    assign offx_acc = kx_reg - origin_x_reg;
    assign offy_acc = ky_reg - origin_y_reg;

    // Cells live at the low bits of their global key, so a scroll keeps them in place.
    assign gx_low   = nox[COORD_BITS-1:0] + col_reg;
    assign gy_low   = noy[COORD_BITS-1:0] + row_reg;
    assign offx_old = dx_reg + KEY_BITS'(col_reg);
    assign offy_old = dy_reg + KEY_BITS'(row_reg);
    assign uncovered = !((offx_old < KEY_BITS'(side_new)) && (offy_old < KEY_BITS'(side_new)));

    // Status to the controller.
    always_comb
    begin
        stat.is_move    = (req_reg == REQ_MOVE);
        stat.is_read    = (req_reg == REQ_READ);
        stat.is_write   = (req_reg == REQ_WRITE);
        stat.need_init  = !ready_reg || (radius_use_reg != r_reg);
        stat.moved      = (dx_now != '0) || (dy_now != '0);
        stat.in_window  = ready_reg && (offx_acc < KEY_BITS'(side_use))
                          && (offy_acc < KEY_BITS'(side_use));
        stat.init_mode  = init_reg;
        stat.sweep_last = (col_reg == side_new - 1'b1) && (row_reg == side_new - 1'b1);
    end

    // RAM port: the sweep owns it while it runs, otherwise the access request.
    always_comb
    begin
        if (cmd.sweep_step)
        begin
            ram_addr  = {gy_low, gx_low};
            ram_we    = init_reg || uncovered;
            ram_wdata = empty_reg;
        end
        else
        begin
            ram_addr  = {ky_reg[COORD_BITS-1:0], kx_reg[COORD_BITS-1:0]};
            ram_we    = cmd.ram_write;
            ram_wdata = wd_reg;
        end
    end

    rgss_ram #(
        .WIDTH (CELL_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .addr  (ram_addr),
        .we    (ram_we),
        .re    (cmd.ram_read),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Control state: configuration, window state and the result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_radius_reg <= RAD_BITS'(16);
            empty_reg      <= '0;
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            radius_use_reg <= '0;
            ready_reg      <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_RADIUS))
            begin
                cfg_radius_reg <= cfg_data[RAD_BITS-1:0];
            end
            if (cfg_we && (cfg_index == CFG_EMPTY))
            begin
                empty_reg <= CELL_BITS'(cfg_data);
            end
            if (cmd.sweep_step && stat.sweep_last)
            begin
                origin_x_reg   <= nox;
                origin_y_reg   <= noy;
                radius_use_reg <= r_reg;
                ready_reg      <= 1'b1;
            end
            done_reg <= cmd.finish;
        end
    end

    // Payload registers: captured request, sweep position and result fields.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req_type;
            kx_reg  <= key_x;
            ky_reg  <= key_y;
            wd_reg  <= CELL_BITS'(write_data);
            r_reg   <= r_eff;
        end
        if (cmd.sweep_start)
        begin
            init_reg <= stat.need_init;
            dx_reg   <= dx_now;
            dy_reg   <= dy_now;
            col_reg  <= '0;
            row_reg  <= '0;
        end
        else if (cmd.sweep_step)
        begin
            if (col_reg == side_new - 1'b1)
            begin
                col_reg <= '0;
                row_reg <= row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
        if (cmd.finish)
        begin
            status_reg    <= cmd.fin_status;
            read_data_reg <= cmd.use_rd ? DATA_BITS'(ram_rdata) : '0;
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign read_data = read_data_reg;

endmodule

[rtl/rgss_ctrl.sv]
// Controller: sequences request decode, window sweeps and cell accesses.
module rgss_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  rgss_pkg::rgss_stat_t stat,
    output rgss_pkg::rgss_cmd_t  cmd,
    output logic                 busy
);
    import rgss_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_SWEEP,
        S_RDWAIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.is_move)
                begin
                    if (stat.need_init || stat.moved)
                    begin
                        cmd.sweep_start = 1'b1;
                        state_next      = S_SWEEP;
                    end
                    else
                    begin
                        cmd.finish     = 1'b1;
                        cmd.fin_status = ST_UNCHANGED;
                        state_next     = S_IDLE;
                    end
                end
                else if (stat.is_read && stat.in_window)
                begin
                    cmd.ram_read = 1'b1;
                    state_next   = S_RDWAIT;
                end
                else
                begin
                    cmd.ram_write  = stat.is_write && stat.in_window;
                    cmd.finish     = 1'b1;
                    cmd.fin_status = (stat.is_write && stat.in_window) ? ST_INSIDE
                                                                       : ST_OUTSIDE;
                    state_next     = S_IDLE;
                end
            end
            S_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = stat.init_mode ? ST_REINIT : ST_SHIFTED;
                    state_next     = S_IDLE;
                end
            end
            S_RDWAIT:
            begin
                cmd.finish     = 1'b1;
                cmd.fin_status = ST_INSIDE;
                cmd.use_rd     = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

[rtl/rgss_checker.sv]
// Port-level checker of the rolling grid scroll store and its bind.
`include "assert_macros.svh"

module rgss_port_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           done,
    input logic [1:0]                     status,
    input logic [rgss_pkg::DATA_BITS-1:0] read_data
);
    import rgss_pkg::*;

    // An accepted request keeps the block busy in the next cycle.
    `CHK_NEXT(a_start_busy, clk, rst_n, start && !busy, busy && !done)
    // A result beat only appears as the block returns to idle.
    `CHK_SAME(a_done_idle, clk, rst_n, done, !busy)
    // A result beat follows a busy cycle.
    `CHK_SAME(a_done_after_busy, clk, rst_n, done, $past(busy))
    // Status never takes the unused code.
    `CHK_SAME(a_status_code, clk, rst_n, done, status != 2'd3)
    // Nonzero read data only comes with an inside report.
    `CHK_SAME(a_rd_inside, clk, rst_n, done && (read_data != '0), status == ST_INSIDE)

endmodule

bind rolling_grid_scroll_store_top rgss_port_checker u_rgss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .status    (status),
    .read_data (read_data)
);

[tb/rgss_checker.sv]
// Checker for the rolling grid scroll store: predicts each request's result and compares it.
module rgss_checker
    import rgss_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    input  logic                    start,
    input  logic                    busy,
    input  logic [1:0]              req_type,
    input  logic [KEY_BITS-1:0]     key_x,
    input  logic [KEY_BITS-1:0]     key_y,
    input  logic [DATA_BITS-1:0]    write_data,
    input  logic                    done,
    input  logic [1:0]              status,
    input  logic [DATA_BITS-1:0]    read_data,
    output int                      errors,
    output int                      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS = SIDE_MAX * SIDE_MAX;

    typedef struct {
        logic [1:0]           status;
        logic [DATA_BITS-1:0] read_data;
    } grid_result_t;

    grid_result_t         expected_results[$];
    logic [RAD_BITS-1:0]  radius_reg;
    logic [CELL_BITS-1:0] empty_reg;
    logic [CELL_BITS-1:0] cells[CELLS];
    logic [CELL_BITS-1:0] old_cells[CELLS];
    logic [KEY_BITS-1:0]  org_x;
    logic [KEY_BITS-1:0]  org_y;
    logic [RAD_BITS-1:0]  radius_used;
    logic                 ready;

    assign pending = expected_results.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    endtask

    // Window placement: reinitialize, scroll by the origin delta, or leave unchanged.
    function automatic logic [1:0] move_window(input logic [31:0] cx, input logic [31:0] cy);
        int           r;
        longint       side;
        logic [31:0]  nox;
        logic [31:0]  noy;
        longint       dx;
        longint       dy;
        longint       sc;
        longint       sr;
        r = (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
        side = 2 * r + 1;
        nox = cx - r;
        noy = cy - r;
        if (!ready || radius_used != r)
        begin
            foreach (cells[i])
                cells[i] = empty_reg;
            org_x = nox;
            org_y = noy;
            radius_used = RAD_BITS'(r);
            ready = 1'b1;
            return ST_REINIT;
        end
        dx = longint'(signed'(nox - org_x));
        dy = longint'(signed'(noy - org_y));
        if (dx == 0 && dy == 0)
            return ST_UNCHANGED;
        old_cells = cells;
        for (longint row = 0; row < side; row++)
        begin
            for (longint col = 0; col < side; col++)
            begin
                sc = col + dx;
                sr = row + dy;
                if (sc >= 0 && sc < side && sr >= 0 && sr < side)
                    cells[row * side + col] = old_cells[sr * side + sc];
                else
                    cells[row * side + col] = empty_reg;
            end
        end
        org_x = nox;
        org_y = noy;
        return ST_SHIFTED;
    endfunction

    // Works out the result of one request and updates the predicted store.
    function automatic grid_result_t predict_access(input logic [1:0] req,
            input logic [31:0] kx, input logic [31:0] ky, input logic [31:0] wd);
        grid_result_t res;
        logic [31:0]  side;
        logic [31:0]  c;
        logic [31:0]  rw;
        res.status = ST_OUTSIDE;
        res.read_data = '0;
        side = 2 * radius_used + 1;
        c = kx - org_x;
        rw = ky - org_y;
        if (req == REQ_MOVE)
            res.status = move_window(kx, ky);
        else if ((req == REQ_READ || req == REQ_WRITE) && ready && c < side && rw < side)
        begin
            res.status = ST_INSIDE;
            if (req == REQ_READ)
                res.read_data = cells[rw * side + c];
            else
                cells[rw * side + c] = wd;
        end
        return res;
    endfunction

    // Results are compared first, then the newly accepted beat is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        grid_result_t want;
        if (!rst_n)
        begin
            radius_reg = 5'd16;
            empty_reg = '0;
            org_x = '0;
            org_y = '0;
            radius_used = '0;
            ready = 1'b0;
            expected_results.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                    report("unexpected result, status", status, 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                        report("status", status, want.status);
                    if (read_data !== want.read_data)
                        report("read_data", read_data, want.read_data);
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_RADIUS)
                    radius_reg = cfg_data[RAD_BITS-1:0];
                else if (cfg_index == CFG_EMPTY)
                    empty_reg = cfg_data[CELL_BITS-1:0];
            end
            if (start && !busy)
                expected_results.push_back(predict_access(req_type, key_x, key_y, write_data));
        end
    end

    initial errors = 0;
endmodule

[tb/tb.sv]
// Testbench top for the rolling grid scroll store: stimulus, idling and the verdict.
module tb;
    import rgss_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]     cfg_data;
    logic                    start;
    logic                    busy;
    logic [1:0]              req_type;
    logic [KEY_BITS-1:0]     key_x;
    logic [KEY_BITS-1:0]     key_y;
    logic [DATA_BITS-1:0]    write_data;
    logic                    done;
    logic [1:0]              status;
    logic [DATA_BITS-1:0]    read_data;
    int                      errors;
    int                      pending;
    int                      cycles;
    int                      idle_pct;
    int                      cur_r;
    logic [31:0]             cur_cx;
    logic [31:0]             cur_cy;

    rolling_grid_scroll_store_top i_dut (.*);

    rgss_checker i_checker (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Timeout watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // Presents one request beat and holds it until accepted, then maybe idles.
    task automatic send_req(input logic [1:0] req, input logic [31:0] kx,
            input logic [31:0] ky, input logic [31:0] wd);
        req_type = req;
        key_x = kx;
        key_y = ky;
        write_data = wd;
        start = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        if (req == REQ_MOVE)
        begin
            cur_cx = kx;
            cur_cy = ky;
        end
        if ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 4))
                @(negedge clk);
        end
    endtask

    // Waits until the block is idle and every expected result has come.
    task automatic drain;
        start = 1'b0;
        @(posedge clk);
        while (busy || pending != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
        drain();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        if (idx == CFG_RADIUS)
            cur_r = val[4:0];
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Random requests, mostly moves and accesses near the current window.
    task automatic random_phase(input int count, input int radius);
        int pick;
        int off_x;
        int off_y;
        write_reg(CFG_RADIUS, radius);
        write_reg(CFG_EMPTY, $urandom);
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            off_x = int'($urandom_range(0, 2 * cur_r + 2)) - (cur_r + 1);
            off_y = int'($urandom_range(0, 2 * cur_r + 2)) - (cur_r + 1);
            if (n == count / 2 && idle_pct > 0)
                drain();
            if (pick < 3)
                send_req(REQ_MOVE, $urandom, $urandom, $urandom);
            else if (pick < 14)
                send_req(REQ_MOVE, cur_cx + off_x / 2, cur_cy + off_y / 2, $urandom);
            else if (pick < 22)
                send_req(2'($urandom_range(1, 3)), $urandom, $urandom, $urandom);
            else
                send_req(2'($urandom_range(1, 2)), cur_cx + off_x, cur_cy + off_y, $urandom);
        end
    endtask

    initial
    begin
        cycles = 0;
        idle_pct = 0;
        cur_r = 16;
        cur_cx = '0;
        cur_cy = '0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_RADIUS;
        cfg_data = '0;
        start = 1'b0;
        req_type = REQ_MOVE;
        key_x = '0;
        key_y = '0;
        write_data = '0;
        repeat (6)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Accesses before any move, and the unused request code.
        send_req(REQ_READ, 0, 0, 0);
        send_req(REQ_WRITE, 0, 0, 32'hFFFF_FFFF);
        send_req(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Default radius: corners, edges, outside cells, unchanged and shifted moves.
        send_req(REQ_MOVE, 100, -50, 0);
        send_req(REQ_WRITE, 84, -66, 32'hA5A5_5A5A);
        send_req(REQ_WRITE, 116, -34, 32'h8000_0001);
        send_req(REQ_READ, 84, -66, 0);
        send_req(REQ_READ, 117, -34, 0);
        send_req(REQ_WRITE, 83, -66, 32'h1234_5678);
        send_req(REQ_MOVE, 100, -50, 0);
        send_req(REQ_MOVE, 101, -49, 0);
        send_req(REQ_READ, 84, -66, 0);
        send_req(REQ_READ, 116, -34, 0);
        send_req(REQ_READ, 117, -33, 0);

        // Radius zero at the wrap-around of the key range.
        write_reg(CFG_RADIUS, 0);
        write_reg(CFG_EMPTY, 32'hFFFF_FFFF);
        send_req(REQ_MOVE, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        send_req(REQ_READ, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        send_req(REQ_WRITE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0F0F_F0F0);
        send_req(REQ_READ, 32'h8000_0000, 32'h8000_0000, 0);
        send_req(REQ_MOVE, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_req(REQ_READ, 32'h8000_0000, 32'h7FFF_FFFF, 0);

        // Largest radius: one clear and one scroll.
        write_reg(CFG_RADIUS, 31);
        send_req(REQ_MOVE, 0, 0, 0);
        send_req(REQ_WRITE, 31, 31, 32'hDEAD_BEEF);
        send_req(REQ_MOVE, 5, 3, 0);
        send_req(REQ_READ, 26, 28, 0);
        write_reg(CFG_EMPTY, 0);

        // Random phases: sender idles, then the other split, then no idling.
        idle_pct = 36;
        random_phase(38, 3);
        idle_pct = 49;
        random_phase(38, 1);
        idle_pct = 0;
        random_phase(38, 7);

        drain();
        repeat (20)
            @(posedge clk);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
